/* rtl/mrmic_pkg.sv */
// Shared types, constants and the axis packing function of the mesh index converter.
// Used by every module of the converter; depends on nothing.
package mrmic_pkg;

  localparam int MAX_AXES     = 3;
  localparam int AXIS_SLOTS   = 3;
  localparam int COUNT_W      = 16;
  localparam int INDEX_W      = 32;
  localparam int TOTAL_W      = 48;
  localparam int SUM_W        = 50;
  localparam int QUO_W        = 2 * COUNT_W;
  localparam int NUM_CELLS    = QUO_W;
  localparam int FRONT_STAGES = 3;
  localparam int LATENCY      = FRONT_STAGES + NUM_CELLS + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int KEPT_W       = 2;

  localparam logic OP_LIFT    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_C = 2'd2;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] linear_index;
    count_t             coord_first;
    count_t             coord_second;
    count_t             coord_third;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_out;
    count_t             out_first;
    count_t             out_second;
    count_t             out_third;
    logic [KEPT_W-1:0]  kept_axes;
    logic               range_error;
  } result_t;

  // Kept axes packed from slot 0; empty slots read as a count of one.
  typedef struct packed {
    count_t [AXIS_SLOTS-1:0] cnt;
    logic [KEPT_W-1:0]       kept;
  } axes_t;

  // Word handed from cell to cell along the division chain.
  typedef struct packed {
    logic               valid;
    logic               op;
    logic               err;
    logic [INDEX_W-1:0] word;
    logic [QUO_W-1:0]   quo;
  } cell_word_t;

  function automatic axes_t pack_axes(count_t a, count_t b, count_t c);
    count_t      raw [AXIS_SLOTS];
    axes_t       r;
    logic [KEPT_W-1:0] n;
    raw[0] = a;
    raw[1] = b;
    raw[2] = c;
    n = '0;
    for (int d = 0; d < AXIS_SLOTS; d++) begin
      r.cnt[d] = count_t'(1);
    end
    for (int d = 0; d < AXIS_SLOTS; d++) begin
      if (d < MAX_AXES && raw[d] > count_t'(1)) begin
        r.cnt[n] = raw[d];
        n = n + KEPT_W'(1);
      end
    end
    r.kept = n;
    return r;
  endfunction

endpackage

/* rtl/mrmic_front.sv */
// Entry stages of the mesh index converter: stride and total derivation, range check,
// projection products and weighted sum. Depends on mrmic_pkg.
module mrmic_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  mrmic_pkg::item_t                  item,
  input  mrmic_pkg::axes_t                  axes,
  output logic [mrmic_pkg::INDEX_W-1:0]     s2,
  output mrmic_pkg::cell_word_t             dout
);

  logic [mrmic_pkg::TOTAL_W-1:0] total;

  // stage one: captured item
  logic                          st1_valid;
  mrmic_pkg::item_t              st1;

  // stage two: products and coordinate check
  logic                          st2_valid;
  logic                          st2_op;
  logic [mrmic_pkg::INDEX_W-1:0] st2_idx;
  mrmic_pkg::count_t             st2_c0;
  logic [mrmic_pkg::INDEX_W-1:0] st2_p1;
  logic [mrmic_pkg::TOTAL_W-1:0] st2_p2;
  logic                          st2_cerr;

  logic                          cerr_next;
  logic [mrmic_pkg::SUM_W-1:0]   sum;
  logic                          ovf;
  mrmic_pkg::cell_word_t         dout_next;

  // Follow the count registers; s2 is registered from the counts and total from s2.
  always_ff @(posedge clk) begin
    s2    <= mrmic_pkg::INDEX_W'(axes.cnt[0]) * mrmic_pkg::INDEX_W'(axes.cnt[1]);
    total <= mrmic_pkg::TOTAL_W'(s2) * mrmic_pkg::TOTAL_W'(axes.cnt[2]);
  end

  always_comb begin
    cerr_next = 1'b0;
    if (axes.kept >= mrmic_pkg::KEPT_W'(1) && st1.coord_first >= axes.cnt[0]) begin
      cerr_next = 1'b1;
    end
    if (axes.kept >= mrmic_pkg::KEPT_W'(2) && st1.coord_second >= axes.cnt[1]) begin
      cerr_next = 1'b1;
    end
    if (axes.kept >= mrmic_pkg::KEPT_W'(3) && st1.coord_third >= axes.cnt[2]) begin
      cerr_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else begin
      st1_valid <= accept;
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1 <= item;
    end
    st2_op   <= st1.op;
    st2_idx  <= st1.linear_index;
    st2_cerr <= cerr_next;
    st2_c0   <= (axes.kept >= mrmic_pkg::KEPT_W'(1)) ? st1.coord_first : '0;
    st2_p1   <= (axes.kept >= mrmic_pkg::KEPT_W'(2))
                ? mrmic_pkg::INDEX_W'(st1.coord_second) * mrmic_pkg::INDEX_W'(axes.cnt[0])
                : '0;
    st2_p2   <= (axes.kept >= mrmic_pkg::KEPT_W'(3))
                ? mrmic_pkg::TOTAL_W'(st1.coord_third) * mrmic_pkg::TOTAL_W'(s2)
                : '0;
  end

  always_comb begin
    sum = mrmic_pkg::SUM_W'(st2_c0) + mrmic_pkg::SUM_W'(st2_p1) + mrmic_pkg::SUM_W'(st2_p2);
    ovf = |sum[mrmic_pkg::SUM_W-1:mrmic_pkg::INDEX_W];
    dout_next       = '0;
    dout_next.valid = st2_valid;
    dout_next.op    = st2_op;
    if (st2_op == mrmic_pkg::OP_LIFT) begin
      dout_next.err  = mrmic_pkg::TOTAL_W'(st2_idx) >= total;
      dout_next.word = st2_idx;
    end else begin
      dout_next.err = st2_cerr | ovf;
      if (st2_cerr) begin
        dout_next.word = '0;
      end else if (ovf) begin
        dout_next.word = '1;
      end else begin
        dout_next.word = sum[mrmic_pkg::INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= dout_next.valid;
    end
    dout.op   <= dout_next.op;
    dout.err  <= dout_next.err;
    dout.word <= dout_next.word;
    dout.quo  <= dout_next.quo;
  end

endmodule

/* rtl/mrmic_cell.sv */
// One cell of the division chain: a single restoring quotient bit per cycle.
// Depends on mrmic_pkg.
module mrmic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mrmic_pkg::cell_word_t         din,
  input  logic [mrmic_pkg::TOTAL_W-1:0] dsh,
  output mrmic_pkg::cell_word_t         dout
);

  logic ge;
  logic step;

  assign ge   = mrmic_pkg::TOTAL_W'(din.word) >= dsh;
  assign step = (din.op == mrmic_pkg::OP_LIFT) && !din.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.op  <= din.op;
    dout.err <= din.err;
    // subtract the shifted divisor when it fits, else hold the remainder
    dout.word <= (step && ge) ? din.word - dsh[mrmic_pkg::INDEX_W-1:0] : din.word;
    dout.quo  <= {din.quo[mrmic_pkg::QUO_W-2:0], step & ge};
  end

endmodule

/* rtl/mixed_radix_mesh_index_convert_core.sv */
// Top level of the mixed-radix mesh index converter: count registers, entry stages,
// the 32-cell division chain and the result register. Depends on mrmic_pkg,
// mrmic_front and mrmic_cell.
//
// Converts between a linear node index and the coordinates of a mesh of up to three
// axes. Write the node count of each axis through cfg_we/cfg_index/cfg_data while no
// word is in flight; axes with a count of 0 or 1 are dropped and the rest are packed
// from the first coordinate slot. A word is taken at every clock edge where start is
// high and busy is low, one per cycle with no gaps. Each word gives exactly one result,
// in order, shown for a single cycle with done high. The receiver cannot stall the
// block, so sample result whenever done is high. The pipeline is made of three entry
// stages (operand capture, projection products, range check against the total node
// count), a chain of 32 division cells that each resolve one quotient bit (16 for the
// highest coordinate, 16 for the middle one), and the result register. busy is a
// registered copy of rst. Lift outside the mesh returns zero coordinates with
// range_error set; project with a coordinate outside its axis returns index 0, and a
// sum beyond 32 bits saturates, both with range_error set.
module mixed_radix_mesh_index_convert_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mrmic_pkg::item_t                item,
  output logic                            done,
  output mrmic_pkg::result_t              result,
  input  logic                            cfg_we,
  input  logic [mrmic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrmic_pkg::COUNT_W-1:0]   cfg_data
);

  mrmic_pkg::count_t             count_a;
  mrmic_pkg::count_t             count_b;
  mrmic_pkg::count_t             count_c;
  mrmic_pkg::axes_t              axes;
  logic                          accept;
  logic [mrmic_pkg::INDEX_W-1:0] s2;

  mrmic_pkg::cell_word_t         link [mrmic_pkg::NUM_CELLS+1];
  logic [mrmic_pkg::TOTAL_W-1:0] dsh  [mrmic_pkg::NUM_CELLS];

  mrmic_pkg::cell_word_t         tail;
  mrmic_pkg::result_t            result_next;

  // Count registers; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= mrmic_pkg::count_t'(1);
      count_b <= mrmic_pkg::count_t'(1);
      count_c <= mrmic_pkg::count_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mrmic_pkg::REG_COUNT_A: count_a <= cfg_data;
        mrmic_pkg::REG_COUNT_B: count_b <= cfg_data;
        mrmic_pkg::REG_COUNT_C: count_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign axes = mrmic_pkg::pack_axes(count_a, count_b, count_c);

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  mrmic_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .axes   (axes),
    .s2     (s2),
    .dout   (link[0])
  );

  // The first half of the chain divides by the top stride, the second half divides the
  // remainder by the count of the first kept axis. Each cell tests one shifted divisor.
  for (genvar i = 0; i < mrmic_pkg::NUM_CELLS; i++) begin : g_chain
    if (i < mrmic_pkg::COUNT_W) begin : g_hi
      assign dsh[i] = mrmic_pkg::TOTAL_W'(s2) << (mrmic_pkg::COUNT_W - 1 - i);
    end else begin : g_lo
      assign dsh[i] = mrmic_pkg::TOTAL_W'(axes.cnt[0]) << (mrmic_pkg::QUO_W - 1 - i);
    end

    mrmic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dsh  (dsh[i]),
      .dout (link[i+1])
    );
  end

  assign tail = link[mrmic_pkg::NUM_CELLS];

  // Shape the result: lift shows coordinates, project shows the index; an error in lift
  // zeroes every field but the flag and kept_axes.
  always_comb begin
    result_next             = '0;
    result_next.kept_axes   = axes.kept;
    result_next.range_error = tail.err;
    if (tail.op == mrmic_pkg::OP_PROJECT) begin
      result_next.index_out = tail.word;
    end else if (!tail.err) begin
      result_next.out_first  = tail.word[mrmic_pkg::COUNT_W-1:0];
      result_next.out_second = tail.quo[mrmic_pkg::COUNT_W-1:0];
      result_next.out_third  = tail.quo[mrmic_pkg::QUO_W-1:mrmic_pkg::COUNT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
    result <= result_next;
  end

endmodule

/* rtl/mrmic_checker.sv */
// Port-level checker for the mesh index converter and its bind to the top level.
// Depends on mrmic_pkg and mixed_radix_mesh_index_convert_core.
module mrmic_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input mrmic_pkg::result_t   result
);

  // every accepted word comes back after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(mrmic_pkg::LATENCY) done)
    else $error("accepted word did not produce a result on time");

  // no result without a matching accept
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, mrmic_pkg::LATENCY))
    else $error("result without an accepted word");

  // a nonzero index comes only from project, which carries no coordinates
  a_index_excl : assert property (@(posedge clk) disable iff (rst)
    (done && result.index_out != '0) |->
      (result.out_first == '0 && result.out_second == '0 && result.out_third == '0))
    else $error("index and coordinates both nonzero");

  // an out-of-mesh result carries no coordinates
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |->
      (result.out_first == '0 && result.out_second == '0 && result.out_third == '0))
    else $error("range error with nonzero coordinates");

endmodule

bind mixed_radix_mesh_index_convert_core mrmic_checker u_mrmic_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for mixed_radix_mesh_index_convert_core: directed corners, then random
// lift/project words over many mesh shapes. Depends on mrmic_pkg and the core RTL only.
module testbench;
  import mrmic_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decoded by nothing
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 200;
  localparam longint unsigned WORD_SPAN = 64'h1_0000_0000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  logic                  done;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COUNT_W-1:0]    cfg_data;

  // Shadow of the count registers and the mesh shape derived from them.
  count_t            mesh_count [AXIS_SLOTS];
  longint unsigned   axis_cnt [AXIS_SLOTS];
  longint unsigned   axis_stride [AXIS_SLOTS];
  int                axis_kept;
  longint unsigned   node_total;

  result_t           expected_words [$];
  int                mismatch_count;
  int                cycle_count;
  bit                steady;

  mixed_radix_mesh_index_convert_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pack kept axes from slot 0 and accumulate their strides.
  function automatic void update_shape();
    axis_kept = 0;
    node_total = 1;
    for (int d = 0; d < AXIS_SLOTS; d++) begin
      axis_cnt[d] = 1;
      axis_stride[d] = 0;
    end
    for (int d = 0; d < MAX_AXES; d++) begin
      if (mesh_count[d] > count_t'(1)) begin
        axis_cnt[axis_kept] = 64'(mesh_count[d]);
        axis_stride[axis_kept] = node_total;
        node_total = node_total * mesh_count[d];
        axis_kept++;
      end
    end
  endfunction

  function automatic result_t convert_mesh_word(item_t w);
    result_t         r;
    longint unsigned rem;
    longint unsigned sum;
    count_t          crd [AXIS_SLOTS];
    count_t          lifted [AXIS_SLOTS];
    r = '0;
    sum = 0;
    crd[0] = w.coord_first;
    crd[1] = w.coord_second;
    crd[2] = w.coord_third;
    for (int d = 0; d < AXIS_SLOTS; d++) lifted[d] = '0;
    r.kept_axes = KEPT_W'(axis_kept);
    if (w.op == OP_LIFT) begin
      rem = 64'(w.linear_index);
      if (rem >= node_total) begin
        r.range_error = 1'b1;
      end else begin
        // Peel coordinates off from the highest kept axis down.
        for (int d = axis_kept - 1; d >= 0; d--) begin
          lifted[d] = count_t'(rem / axis_stride[d]);
          rem = rem % axis_stride[d];
        end
      end
      r.out_first = lifted[0];
      r.out_second = lifted[1];
      r.out_third = lifted[2];
    end else begin
      for (int d = 0; d < axis_kept; d++) begin
        if (crd[d] >= axis_cnt[d]) r.range_error = 1'b1;
        else sum = sum + crd[d] * axis_stride[d];
      end
      if (r.range_error) begin
        sum = 0;
      end else if (sum >= WORD_SPAN) begin
        // Saturate a sum that does not fit the index.
        r.range_error = 1'b1;
        sum = WORD_SPAN - 1;
      end
      r.index_out = sum[INDEX_W-1:0];
    end
    return r;
  endfunction

  function automatic item_t make_word(logic op, logic [INDEX_W-1:0] lin,
                                      count_t c0, count_t c1, count_t c2);
    item_t w;
    w.op = op;
    w.linear_index = lin;
    w.coord_first = c0;
    w.coord_second = c1;
    w.coord_third = c2;
    return w;
  endfunction

  function automatic count_t pick_count();
    case ($urandom_range(9))
      0:       return count_t'(0);
      1:       return count_t'(1);
      2, 3, 4: return count_t'($urandom_range(16, 2));
      5, 6:    return count_t'($urandom_range(1000, 17));
      7:       return count_t'($urandom_range(65534, 1001));
      default: return count_t'(65535);
    endcase
  endfunction

  // Mostly well-formed words for the current shape, with some out of range and some noise.
  function automatic item_t make_random_word();
    item_t  w;
    count_t crd [AXIS_SLOTS];
    w = make_word(1'($urandom_range(1)), $urandom, count_t'($urandom),
                  count_t'($urandom), count_t'($urandom));
    if (w.op == OP_LIFT) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          if (node_total < WORD_SPAN) w.linear_index = $urandom_range(32'(node_total - 1));
        end
        6: w.linear_index = 32'(node_total - 1);
        7: if (node_total < WORD_SPAN) w.linear_index = 32'(node_total);
        default: ;
      endcase
    end else begin
      crd[0] = w.coord_first;
      crd[1] = w.coord_second;
      crd[2] = w.coord_third;
      for (int d = 0; d < axis_kept; d++) begin
        case ($urandom_range(19))
          16:      crd[d] = count_t'(axis_cnt[d] - 1);
          17:      crd[d] = count_t'(axis_cnt[d]);
          18, 19:  ;
          default: crd[d] = count_t'($urandom_range(32'(axis_cnt[d] - 1)));
        endcase
      end
      w.coord_first = crd[0];
      w.coord_second = crd[1];
      w.coord_third = crd[2];
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Unless steady, maybe stay quiet first, then offer one word and hold it until taken.
  task automatic send_word(item_t w);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    expected_words.push_back(convert_mesh_word(w));
  endtask

  // Drop start and wait until every word in flight has come back.
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, count_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_COUNT_A: mesh_count[0] = val;
      REG_COUNT_B: mesh_count[1] = val;
      REG_COUNT_C: mesh_count[2] = val;
      default:     ;
    endcase
  endtask

  task automatic configure_mesh(count_t a, count_t b, count_t c, bit poke_spare);
    write_reg(REG_COUNT_A, a);
    write_reg(REG_COUNT_B, b);
    write_reg(REG_COUNT_C, c);
    if (poke_spare) write_reg(REG_SPARE, count_t'($urandom));
    cfg_we <= 1'b0;
    update_shape();
  endtask

  // Reset counts leave no axis; a count of zero drops its axis the same way.
  task automatic test_flat_mesh();
    send_word(make_word(OP_LIFT, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(OP_LIFT, 32'd1, 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_LIFT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_PROJECT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    wait_quiet();
    configure_mesh(16'd0, 16'd0, 16'd1, 1'b0);
    send_word(make_word(OP_LIFT, 32'd0, 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd7, 16'd9, 16'd3));
    wait_quiet();
  endtask

  // Middle axis dropped: first and third counts pack into slots 0 and 1.
  task automatic test_lift_corners();
    configure_mesh(16'd65535, 16'd1, 16'd300, 1'b0);
    send_word(make_word(OP_LIFT, 32'd0, 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_LIFT, 32'(node_total - 1), 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_LIFT, 32'(node_total), 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_LIFT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0));
    send_word(make_word(OP_LIFT, 32'd65535, 16'd0, 16'd0, 16'd0));
    wait_quiet();
  endtask

  task automatic test_project_corners();
    send_word(make_word(OP_PROJECT, 32'd0, 16'd65534, 16'd299, 16'hFFFF));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd65535, 16'd0, 16'd0));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd0, 16'd300, 16'd0));
    send_word(make_word(OP_PROJECT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'hFFFF));
    wait_quiet();
  endtask

  // Full-size mesh: sums past 32 bits saturate, every 32-bit index lifts.
  task automatic test_saturation();
    configure_mesh(16'd65535, 16'd65535, 16'd65535, 1'b1);
    send_word(make_word(OP_PROJECT, 32'd0, 16'd65534, 16'd65534, 16'd65534));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd65534, 16'd65534, 16'd0));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd0, 16'd0, 16'd1));
    send_word(make_word(OP_PROJECT, 32'd0, 16'd0, 16'd0, 16'd2));
    send_word(make_word(OP_LIFT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0));
    wait_quiet();
  endtask

  task automatic test_random_meshes();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       configure_mesh(16'd65535, 16'd65535, 16'd65535, 1'b0);
        1:       configure_mesh(16'd1, 16'd0, 16'd1, 1'b0);
        2:       configure_mesh(16'd2, 16'd2, 16'd2, 1'b0);
        default: configure_mesh(pick_count(), pick_count(), pick_count(), phase == 5);
      endcase
      steady = (phase == 4);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(make_random_word());
      wait_quiet();
    end
    steady = 1'b0;
  endtask

  // Compare each result with the oldest word still owed.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected", result.index_out, 32'd0);
      end else begin
        want = expected_words.pop_front();
        check_field("index_out", result.index_out, want.index_out);
        check_field("out_first", 32'(result.out_first), 32'(want.out_first));
        check_field("out_second", 32'(result.out_second), 32'(want.out_second));
        check_field("out_third", 32'(result.out_third), 32'(want.out_third));
        check_field("kept_axes", 32'(result.kept_axes), 32'(want.kept_axes));
        check_field("range_error", 32'(result.range_error), 32'(want.range_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mixed_radix_mesh_index_convert_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    steady = 1'b0;
    for (int d = 0; d < AXIS_SLOTS; d++) mesh_count[d] = count_t'(1);
    update_shape();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait_quiet();

    test_flat_mesh();
    test_lift_corners();
    test_project_corners();
    test_saturation();
    test_random_meshes();

    wait_quiet();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("mixed_radix_mesh_index_convert_core regression: pass");
    else
      $display("mixed_radix_mesh_index_convert_core regression: fail");
    $finish;
  end

endmodule
